// ===== hw/rtl/cmd_pkg.sv =====
// Shared types and constants of the complex magnitude detector.
package cmd_pkg;

    // Field and datapath widths.
    localparam int IN_W        = 16;
    localparam int MAG_W       = 16;
    localparam int SQ_W        = 31;
    localparam int SUM_W       = 32;
    localparam int FRAC_SHIFT  = 16;
    localparam int RAD_W       = 48;
    localparam int ROOT_W      = 24;
    localparam int REM_W       = 26;
    localparam int SQRT_STAGES = 12;
    localparam int SQRT_DIGITS = 2;
    localparam int GAIN_W      = 32;
    localparam int PROD_W      = 56;
    localparam int PROD_SHIFT  = 24;
    localparam int PIX_W       = 8;

    // Configuration port.
    localparam int APB_ADDR_W  = 2;
    localparam int APB_DATA_W  = 32;
    localparam logic [APB_ADDR_W-1:0] GAIN_ADDR  = 2'd0;
    localparam logic [GAIN_W-1:0]     GAIN_RESET = 32'h0001_0000;

    // Largest pixel value.
    localparam logic [PIX_W-1:0] PIXEL_MAX = 8'd255;

    // State carried through the square root pipeline.
    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        logic              line_end;
    } sqrt_t;

endpackage

// ===== hw/rtl/cmd_square.sv =====
// Absolute values, squares and sum of squares: two pipeline stages.
module cmd_square (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [cmd_pkg::IN_W-1:0] in_phase,
    input  logic signed [cmd_pkg::IN_W-1:0] quadrature,
    input  logic                       line_end,
    output logic                       out_valid,
    input  logic                       out_ready,
    output cmd_pkg::sqrt_t             out_data
);
    import cmd_pkg::*;

    logic               sq_valid_reg;
    logic [SQ_W-1:0]    i_sq_reg;
    logic [SQ_W-1:0]    q_sq_reg;
    logic               sq_end_reg;
    logic               sq_ready;
    logic [MAG_W-1:0]   i_abs;
    logic [MAG_W-1:0]   q_abs;
    logic [SQ_W-1:0]    i_prod;
    logic [SQ_W-1:0]    q_prod;

    logic               sum_valid_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               sum_end_reg;

    // Magnitudes of the two parts; the most negative value maps to 2^15.
    assign i_abs  = in_phase[IN_W-1]   ? MAG_W'(-in_phase)   : MAG_W'(in_phase);
    assign q_abs  = quadrature[IN_W-1] ? MAG_W'(-quadrature) : MAG_W'(quadrature);
    // A square is at most 2^30, so it fits in the narrower product.
    assign i_prod = SQ_W'(i_abs) * SQ_W'(i_abs);
    assign q_prod = SQ_W'(q_abs) * SQ_W'(q_abs);

    // Each stage takes a new request when empty or when its successor moves.
    assign sq_ready  = !sum_valid_reg || out_ready;
    assign in_ready  = !sq_valid_reg || sq_ready;
    assign out_valid = sum_valid_reg;

    // Stage one: squares.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg <= 1'b0;
        end else if (in_ready) begin
            sq_valid_reg <= in_valid;
        end
        if (in_ready) begin
            i_sq_reg   <= i_prod;
            q_sq_reg   <= q_prod;
            sq_end_reg <= line_end;
        end
    end

    // Stage two: sum of squares, at most 2^31.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sq_ready) begin
            sum_valid_reg <= sq_valid_reg;
        end
        if (sq_ready) begin
            sum_reg     <= SUM_W'(i_sq_reg) + SUM_W'(q_sq_reg);
            sum_end_reg <= sq_end_reg;
        end
    end

    // The radicand carries 16 zero bits so the root has 8 fraction bits.
    always_comb begin
        out_data.rem      = '0;
        out_data.root     = '0;
        out_data.rad      = {sum_reg, {FRAC_SHIFT{1'b0}}};
        out_data.line_end = sum_end_reg;
    end

endmodule

// ===== hw/rtl/cmd_sqrt_stage.sv =====
// One stage of the digit-by-digit square root: two root bits per stage.
module cmd_sqrt_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cmd_pkg::sqrt_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output cmd_pkg::sqrt_t out_data
);
    import cmd_pkg::*;

    logic  valid_reg;
    sqrt_t data_reg;
    sqrt_t data_next;

    // Restoring square root: bring down two radicand bits, try (4*root + 1).
    always_comb begin
        logic [REM_W:0]    cur;
        logic [REM_W:0]    trial;
        logic [REM_W-1:0]  rem_v;
        logic [ROOT_W-1:0] root_v;
        logic [RAD_W-1:0]  rad_v;
        rem_v  = in_data.rem;
        root_v = in_data.root;
        rad_v  = in_data.rad;
        for (int d = 0; d < SQRT_DIGITS; d++) begin
            cur   = {rem_v[REM_W-2:0], rad_v[RAD_W-1 -: 2]};
            trial = {1'b0, root_v, 2'b01};
            if (cur >= trial) begin
                cur    = cur - trial;
                root_v = {root_v[ROOT_W-2:0], 1'b1};
            end else begin
                root_v = {root_v[ROOT_W-2:0], 1'b0};
            end
            rem_v = cur[REM_W-1:0];
            rad_v = {rad_v[RAD_W-3:0], 2'b00};
        end
        data_next.rem      = rem_v;
        data_next.root     = root_v;
        data_next.rad      = rad_v;
        data_next.line_end = in_data.line_end;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/cmd_scale.sv =====
// Gain multiply, floor and saturation to an 8-bit pixel: two pipeline stages.
module cmd_scale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [cmd_pkg::GAIN_W-1:0]   gain,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  cmd_pkg::sqrt_t               in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cmd_pkg::PIX_W-1:0]    pixel,
    output logic                         saturated,
    output logic                         line_end
);
    import cmd_pkg::*;

    logic              mul_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              mul_end_reg;
    logic              mul_ready;

    logic              out_valid_reg;
    logic [PIX_W-1:0]  pixel_reg;
    logic              sat_reg;
    logic              end_reg;
    logic              clip;

    assign mul_ready = !out_valid_reg || out_ready;
    assign in_ready  = !mul_valid_reg || mul_ready;

    // Stage one: Q.8 magnitude times Q16.16 gain gives an exact Q.24 product.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (in_ready) begin
            mul_valid_reg <= in_valid;
        end
        if (in_ready) begin
            prod_reg    <= PROD_W'(in_data.root) * PROD_W'(gain);
            mul_end_reg <= in_data.line_end;
        end
    end

    // Anything at or above 256 in the integer part clips.
    assign clip = |prod_reg[PROD_W-1:PROD_SHIFT+PIX_W];

    // Stage two: output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mul_ready) begin
            out_valid_reg <= mul_valid_reg;
        end
        if (mul_ready) begin
            pixel_reg <= clip ? PIXEL_MAX : prod_reg[PROD_SHIFT +: PIX_W];
            sat_reg   <= clip;
            end_reg   <= mul_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel     = pixel_reg;
    assign saturated = sat_reg;
    assign line_end  = end_reg;

endmodule

// ===== hw/rtl/complex_magnitude_detect.sv =====
// Top level of the complex magnitude detector.
// Usage:
//   The s_ channel takes one complex sample per request: signed 16-bit
//   in-phase and quadrature parts plus an end-of-line mark. The m_ channel
//   delivers one 8-bit pixel per sample, a saturation flag and the copied
//   end-of-line mark, in input order.
//   The pixel is floor(sqrt(I*I + Q*Q) * gain), clipped to 255, with the
//   magnitude kept to 8 fraction bits and gain in unsigned Q16.16.
//   The stages, in order: the squares, their sum, the square root (two
//   root bits per stage), the gain multiply and saturation into the
//   output register. Throughput is one sample per cycle while the
//   receiver keeps m_ready high; every stage is a register with a
//   valid bit, so the pipeline holds up to 16 requests in flight.
//   When the receiver stalls, results stay in their stages and the empty
//   stages keep filling; s_ready drops only once the pipeline is full.
//   The gain register sits on the APB port at byte address 0 and may be
//   written only while the pipeline is empty.
//   Synchronous reset empties the pipeline and sets gain to 1.0.
module complex_magnitude_detect (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Sample channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [cmd_pkg::IN_W-1:0]     s_in_phase,
    input  logic signed [cmd_pkg::IN_W-1:0]     s_quadrature,
    input  logic                                s_line_end_in,
    // Pixel channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [cmd_pkg::PIX_W-1:0]           m_pixel,
    output logic                                m_saturated,
    output logic                                m_line_end_out,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cmd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cmd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cmd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import cmd_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    logic              gain_we;

    logic  sq_valid [SQRT_STAGES+1];
    logic  sq_ready [SQRT_STAGES+1];
    sqrt_t sq_data  [SQRT_STAGES+1];

    // Configuration register.
    assign pready  = 1'b1;
    assign gain_we = psel && penable && pwrite && pready && (paddr == GAIN_ADDR);
    assign prdata  = (paddr == GAIN_ADDR) ? gain_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (gain_we) begin
            gain_reg <= pwdata;
        end
    end

    // Squares and sum.
    cmd_square u_square (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_phase   (s_in_phase),
        .quadrature (s_quadrature),
        .line_end   (s_line_end_in),
        .out_valid  (sq_valid[0]),
        .out_ready  (sq_ready[0]),
        .out_data   (sq_data[0])
    );

    // Square root pipeline.
    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        cmd_sqrt_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_valid[g]),
            .in_ready  (sq_ready[g]),
            .in_data   (sq_data[g]),
            .out_valid (sq_valid[g+1]),
            .out_ready (sq_ready[g+1]),
            .out_data  (sq_data[g+1])
        );
    end

    // Gain and saturation.
    cmd_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (gain_reg),
        .in_valid  (sq_valid[SQRT_STAGES]),
        .in_ready  (sq_ready[SQRT_STAGES]),
        .in_data   (sq_data[SQRT_STAGES]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .pixel     (m_pixel),
        .saturated (m_saturated),
        .line_end  (m_line_end_out)
    );

`ifndef SYNTHESIS
    // A draining receiver never backs up the pipeline.
    a_no_stall_when_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("s_ready low while m_ready high");

    // A clipped pixel always reads as full scale.
    a_sat_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |-> (m_pixel == PIXEL_MAX))
        else $error("saturated pixel not at full scale");

    // Reset leaves no result behind.
    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");
`endif

endmodule
